// ===== hdl/cst_pkg.sv =====
// Shared types and constants of the triangle stiffness block.
package cst_pkg;

    localparam int NODES       = 3;
    localparam int DOFS        = 6;
    localparam int IDX_W       = 3;
    localparam int ENTRY_W     = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_TDATA_W = ((2 * IDX_W + ENTRY_W + 7) / 8) * 8;

    // material register indexes
    localparam logic [CFG_IDX_W-1:0] REG_D11 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_D12 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D13 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_D22 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_D23 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_D33 = 3'd5;

    // status of the bit-serial multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// ===== hdl/cst_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, sign-magnitude.
module cst_mul #(
    parameter int AW = 32,
    parameter int BW = 33
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AW-1:0]     a_in,
    input  logic signed [BW-1:0]     b_in,
    output cst_pkg::mul_stat_t       stat,
    output logic signed [AW+BW-1:0]  prod
);

    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0]    mag_a_reg;
    logic [BW-1:0]    mag_b_reg;
    logic [AW+BW-1:0] acc_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(BW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= a_in[AW-1] ? AW'(-a_in) : AW'(a_in);
            mag_b_reg <= b_in[BW-1] ? BW'(-b_in) : BW'(b_in);
            neg_reg   <= a_in[AW-1] ^ b_in[BW-1];
            acc_reg   <= '0;
        end else if (cnt_reg != '0) begin
            // MSB first: shift the sum, add the multiplicand when the bit is set
            acc_reg   <= {acc_reg[AW+BW-2:0], 1'b0}
                         + (mag_b_reg[BW-1] ? {{BW{1'b0}}, mag_a_reg} : '0);
            mag_b_reg <= {mag_b_reg[BW-2:0], 1'b0};
        end
    end

    assign prod      = neg_reg ? $signed(-acc_reg) : $signed(acc_reg);
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// ===== hdl/cst_queue.sv =====
// Small register FIFO between the front end and the back end.
module cst_queue #(
    parameter int DW    = 16,
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/cst_front.sv =====
// Front end: takes a triangle, forms edge differences and the determinant.
module cst_front #(
    parameter  int W     = 32,
    localparam int REC_W = 9 * W + 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7*W-1:0]   in_fields,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [REC_W-1:0] q_data
);

    localparam int W1   = W + 1;
    localparam int DETW = 2 * W + 3;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_START = 4'b0010,
        F_WAIT  = 4'b0100,
        F_PUSH  = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic             hold_valid_reg;
    logic [7*W-1:0]   hold_reg;
    logic [1:0]       node_reg, node_next;
    logic signed [W-1:0]    x_reg [cst_pkg::NODES];
    logic signed [W1-1:0]   b_reg [cst_pkg::NODES];
    logic signed [W1-1:0]   c_reg [cst_pkg::NODES];
    logic [W-1:0]           thick_reg;
    logic signed [DETW-1:0] det_reg;
    logic [DETW-1:0]        det_mag;

    logic signed [W-1:0]  xin [cst_pkg::NODES];
    logic signed [W-1:0]  yin [cst_pkg::NODES];
    logic signed [W1-1:0] b_new [cst_pkg::NODES];
    logic signed [W1-1:0] c_new [cst_pkg::NODES];

    logic                     load;
    logic                     mul_start;
    cst_pkg::mul_stat_t       mstat;
    logic signed [2*W:0]      prod;

    // vertex unpack and edge differences b_i = y_j - y_k, c_i = x_k - x_j
    always_comb begin
        for (int i = 0; i < cst_pkg::NODES; i++) begin
            xin[i] = hold_reg[2*i*W +: W];
            yin[i] = hold_reg[(2*i+1)*W +: W];
        end
        for (int i = 0; i < cst_pkg::NODES; i++) begin
            b_new[i] = W1'(yin[(i+1)%3]) - W1'(yin[(i+2)%3]);
            c_new[i] = W1'(xin[(i+2)%3]) - W1'(xin[(i+1)%3]);
        end
    end

    assign in_ready  = !hold_valid_reg;
    assign load      = (state_reg == F_IDLE) && hold_valid_reg;
    assign mul_start = (state_reg == F_START);
    assign q_valid   = (state_reg == F_PUSH);
    assign det_mag   = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
    assign q_data    = {(det_reg == '0), det_mag, thick_reg,
                        c_reg[2], c_reg[1], c_reg[0], b_reg[2], b_reg[1], b_reg[0]};

    always_comb begin
        state_next = state_reg;
        node_next  = node_reg;
        case (state_reg)
            F_IDLE: begin
                if (hold_valid_reg) begin
                    node_next  = '0;
                    state_next = F_START;
                end
            end
            F_START: begin
                state_next = F_WAIT;
            end
            F_WAIT: begin
                if (mstat.done) begin
                    if (node_reg == 2'(cst_pkg::NODES - 1)) begin
                        state_next = F_PUSH;
                    end else begin
                        node_next  = node_reg + 1'b1;
                        state_next = F_START;
                    end
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            node_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            node_reg  <= node_next;
            if (in_valid && in_ready) begin
                hold_valid_reg <= 1'b1;
            end else if (load) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_reg <= in_fields;
        end
        if (load) begin
            for (int i = 0; i < cst_pkg::NODES; i++) begin
                x_reg[i] <= xin[i];
                b_reg[i] <= b_new[i];
                c_reg[i] <= c_new[i];
            end
            thick_reg <= hold_reg[6*W +: W];
            det_reg   <= '0;
        end else if (state_reg == F_WAIT && mstat.done) begin
            det_reg <= det_reg + DETW'(prod);
        end
    end

    // det = sum x_i * b_i, one product per node
    cst_mul #(.AW(W), .BW(W1)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (x_reg[node_reg]),
        .b_in    (b_reg[node_reg]),
        .stat    (mstat),
        .prod    (prod)
    );

endmodule

// ===== hdl/cst_back.sv =====
// Back end: forms B^T D B per entry, scales by thickness, divides, emits.
module cst_back #(
    parameter  int W         = 32,
    parameter  int FRAC_BITS = 16,
    localparam int REC_W     = 9 * W + 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [REC_W-1:0]                    q_data,
    input  logic [6*W-1:0]                      d_mat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cst_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam int W1    = W + 1;
    localparam int DETW  = 2 * W + 3;
    localparam int EW    = 2 * W + 3;
    localparam int SW    = 3 * W + 6;
    localparam int AW    = SW;
    localparam int PW    = AW + W1;
    localparam int QW    = cst_pkg::ENTRY_W;
    localparam int SH_N  = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
    localparam int SH_D  = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int NMW   = PW + SH_N;
    localparam int DENW  = DETW + 1 + SH_D;
    localparam int RW    = ((NMW > DENW + QW) ? NMW : DENW + QW) + 1;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int PAD_W = cst_pkg::OUT_TDATA_W - 2 * cst_pkg::IDX_W - QW;
    localparam logic [cst_pkg::IDX_W-1:0] LAST_IDX = cst_pkg::IDX_W'(cst_pkg::DOFS - 1);

    typedef enum logic [9:0] {
        B_IDLE    = 10'b0000000001,
        B_RSTART  = 10'b0000000010,
        B_RWAIT   = 10'b0000000100,
        B_ESTART  = 10'b0000001000,
        B_EWAIT   = 10'b0000010000,
        B_TSTART  = 10'b0000100000,
        B_TWAIT   = 10'b0001000000,
        B_DIVINIT = 10'b0010000000,
        B_DIV     = 10'b0100000000,
        B_EMIT    = 10'b1000000000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [cst_pkg::IDX_W-1:0] row_reg, row_next, col_reg, col_next, t_reg, t_next;
    logic [CNT_W-1:0]          bit_cnt_reg, bit_cnt_next;

    logic signed [W1-1:0]  b_reg [cst_pkg::NODES];
    logic signed [W1-1:0]  c_reg [cst_pkg::NODES];
    logic [W-1:0]          thick_reg;
    logic [DETW-1:0]       detmag_reg;
    logic                  degen_reg;
    logic signed [EW-1:0]  e_reg [3];
    logic signed [SW-1:0]  s_reg;
    logic [RW-1:0]         rem_reg, ds_reg;
    logic [QW-1:0]         quo_reg;
    logic                  big_reg, neg_reg;

    logic                  m_tvalid_reg;

    logic                  in_row, in_thick, odd, term;
    logic [1:0]            node, krow, lsel;
    logic [cst_pkg::CFG_IDX_W-1:0] dsel;
    logic [W-1:0]          d_val;
    logic signed [W1-1:0]  cval;
    logic signed [AW-1:0]  mul_a;
    logic signed [W1-1:0]  mul_b;
    logic                  mul_start;
    cst_pkg::mul_stat_t    mstat;
    logic signed [PW-1:0]  prod;
    logic [PW-1:0]         n_mag;
    logic [RW-1:0]         nm, den, diff;
    logic                  geq;
    logic [QW-1:0]         val;
    logic                  emit_go;

    // operand selection: row phase forms e = D col_i, entry phase col_j . e
    assign in_row   = (state_reg == B_RSTART) || (state_reg == B_RWAIT);
    assign in_thick = (state_reg == B_TSTART) || (state_reg == B_TWAIT);
    assign node     = in_row ? row_reg[2:1] : col_reg[2:1];
    assign odd      = in_row ? row_reg[0] : col_reg[0];
    assign term     = t_reg[0];
    assign krow     = t_reg[2:1];
    assign lsel     = term ? 2'd2 : (odd ? 2'd1 : 2'd0);
    assign cval     = (term ^ odd) ? c_reg[node] : b_reg[node];

    // symmetric D: pick the stored entry for (k, l)
    always_comb begin
        case ({krow, lsel})
            {2'd0, 2'd0}:                 dsel = cst_pkg::REG_D11;
            {2'd0, 2'd1}, {2'd1, 2'd0}:   dsel = cst_pkg::REG_D12;
            {2'd0, 2'd2}, {2'd2, 2'd0}:   dsel = cst_pkg::REG_D13;
            {2'd1, 2'd1}:                 dsel = cst_pkg::REG_D22;
            {2'd1, 2'd2}, {2'd2, 2'd1}:   dsel = cst_pkg::REG_D23;
            {2'd2, 2'd2}:                 dsel = cst_pkg::REG_D33;
            default:                      dsel = cst_pkg::REG_D11;
        endcase
    end
    assign d_val = d_mat[dsel*W +: W];

    assign mul_a = in_row   ? AW'($signed(d_val)) :
                   in_thick ? s_reg : AW'(e_reg[lsel]);
    assign mul_b = in_thick ? $signed({1'b0, thick_reg}) : cval;
    assign mul_start = (state_reg == B_RSTART) || (state_reg == B_ESTART)
                       || (state_reg == B_TSTART);

    // divider setup and step
    assign n_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
    assign nm    = RW'(n_mag) << SH_N;
    assign den   = RW'(detmag_reg) << (1 + SH_D);
    assign geq   = (rem_reg >= ds_reg);
    assign diff  = rem_reg - ds_reg;

    // saturate to signed 64 bits
    always_comb begin
        if (degen_reg) begin
            val = '0;
        end else if (neg_reg) begin
            if (big_reg || (quo_reg[QW-1] && (quo_reg[QW-2:0] != '0))) begin
                val = {1'b1, {(QW-1){1'b0}}};
            end else begin
                val = -quo_reg;
            end
        end else begin
            if (big_reg || quo_reg[QW-1]) begin
                val = {1'b0, {(QW-1){1'b1}}};
            end else begin
                val = quo_reg;
            end
        end
    end

    assign q_ready = (state_reg == B_IDLE);
    assign emit_go = (state_reg == B_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        t_next       = t_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    row_next   = '0;
                    col_next   = '0;
                    t_next     = '0;
                    state_next = q_data[REC_W-1] ? B_EMIT : B_RSTART;
                end
            end
            B_RSTART: state_next = B_RWAIT;
            B_RWAIT: begin
                if (mstat.done) begin
                    if (t_reg == LAST_IDX) begin
                        t_next     = '0;
                        state_next = B_ESTART;
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = B_RSTART;
                    end
                end
            end
            B_ESTART: state_next = B_EWAIT;
            B_EWAIT: begin
                if (mstat.done) begin
                    if (term) begin
                        t_next     = '0;
                        state_next = B_TSTART;
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = B_ESTART;
                    end
                end
            end
            B_TSTART: state_next = B_TWAIT;
            B_TWAIT: begin
                if (mstat.done) begin
                    state_next = B_DIVINIT;
                end
            end
            B_DIVINIT: begin
                bit_cnt_next = CNT_W'(QW);
                state_next   = B_DIV;
            end
            B_DIV: begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == CNT_W'(1)) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (emit_go) begin
                    if (col_reg == LAST_IDX) begin
                        col_next = '0;
                        if (row_reg == LAST_IDX) begin
                            state_next = B_IDLE;
                        end else begin
                            row_next   = row_reg + 1'b1;
                            state_next = degen_reg ? B_EMIT : B_RSTART;
                        end
                    end else begin
                        col_next   = col_reg + 1'b1;
                        state_next = degen_reg ? B_EMIT : B_ESTART;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            t_reg        <= '0;
            bit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            t_reg       <= t_next;
            bit_cnt_reg <= bit_cnt_next;
            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    for (int i = 0; i < cst_pkg::NODES; i++) begin
                        b_reg[i] <= q_data[i*W1 +: W1];
                        c_reg[i] <= q_data[(3+i)*W1 +: W1];
                    end
                    thick_reg  <= q_data[6*W1 +: W];
                    detmag_reg <= q_data[6*W1+W +: DETW];
                    degen_reg  <= q_data[REC_W-1];
                end
            end
            B_RWAIT: begin
                if (mstat.done) begin
                    e_reg[krow] <= term ? e_reg[krow] + $signed(prod[EW-1:0])
                                        : $signed(prod[EW-1:0]);
                end
            end
            B_EWAIT: begin
                if (mstat.done) begin
                    s_reg <= term ? s_reg + $signed(prod[SW-1:0])
                                  : $signed(prod[SW-1:0]);
                end
            end
            B_DIVINIT: begin
                rem_reg <= nm;
                ds_reg  <= den << (QW - 1);
                quo_reg <= '0;
                big_reg <= (nm >= (den << QW));
                neg_reg <= prod[PW-1];
            end
            B_DIV: begin
                if (geq) begin
                    rem_reg <= diff;
                end
                quo_reg <= {quo_reg[QW-2:0], geq};
                ds_reg  <= ds_reg >> 1;
            end
            default: begin
            end
        endcase
        if (emit_go) begin
            m_tdata <= {{PAD_W{1'b0}}, val, col_reg, row_reg};
            m_tlast <= (row_reg == LAST_IDX) && (col_reg == LAST_IDX);
            m_tuser <= degen_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    cst_mul #(.AW(AW), .BW(W1)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .stat    (mstat),
        .prod    (prod)
    );

    a_div_cnt_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (bit_cnt_reg != '0) |-> (state_reg == B_DIV))
        else $error("divide counter running outside divide");

    a_mul_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mstat.busy)
        else $error("multiplier restarted while busy");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser) |-> (m_tdata[2*cst_pkg::IDX_W +: QW] == '0))
        else $error("degenerate entry with nonzero value");

endmodule

// ===== hdl/cst_triangle_stiffness.sv =====
// Top level of the constant strain triangle stiffness block.
// One triangle transfer on the s_ side (three vertices and a thickness) yields 36
// transfers on the m_ side, the 6x6 element stiffness K = t*A*B^T D B in row-major
// order, tlast on the last one. D is the symmetric 3x3 material matrix held in six
// registers written through cfg_we/cfg_idx/cfg_wdata (index 0..5: d_11, d_12, d_13,
// d_22, d_23, d_33; other indexes are ignored). The user must write them only while
// the block is idle; the block itself does not enforce this. Inputs are
// Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS, results signed Q32.32, truncated toward zero and
// saturated. A zero-area triangle gives 36 zero entries with tuser set.
// The back end shares one bit-serial multiplier and a 64-step restoring divider.
// Per entry it forms 3 products and a division; per row another 6 products. A
// degenerate element skips the products and divisions.
// The front end computes the determinant (3 products) and queues up to two
// triangles ahead, with one more held at the input, so it overlaps the back end.
module cst_triangle_stiffness #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [COORD_WIDTH-1:0]              cfg_wdata,
    // triangle in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_first, y_first, x_second, y_second, x_third, y_third, thickness
    input  logic [((7*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // stiffness entries out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row_index[2:0], col_index[5:3], entry_value[69:6]
    output logic [cst_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    // degenerate
    output logic                                m_tuser
);

    localparam int W       = COORD_WIDTH;
    localparam int REC_W   = 9 * W + 10;
    localparam int Q_DEPTH = 2;

    logic [W-1:0]     d_reg [6];
    logic [6*W-1:0]   d_mat;

    logic             fq_valid, fq_ready, bq_valid, bq_ready;
    logic [REC_W-1:0] fq_data, bq_data;

    // material registers; writes to unused indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                d_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_idx)
                cst_pkg::REG_D11: d_reg[0] <= cfg_wdata;
                cst_pkg::REG_D12: d_reg[1] <= cfg_wdata;
                cst_pkg::REG_D13: d_reg[2] <= cfg_wdata;
                cst_pkg::REG_D22: d_reg[3] <= cfg_wdata;
                cst_pkg::REG_D23: d_reg[4] <= cfg_wdata;
                cst_pkg::REG_D33: d_reg[5] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign d_mat = {d_reg[5], d_reg[4], d_reg[3], d_reg[2], d_reg[1], d_reg[0]};

    cst_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_fields (s_tdata[7*W-1:0]),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    cst_queue #(.DW(REC_W), .DEPTH(Q_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    cst_back #(.W(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (bq_valid),
        .q_ready  (bq_ready),
        .q_data   (bq_data),
        .d_mat    (d_mat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
